// ===== sv/itfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itfa_pkg
// Types, codes and the control store shared by the integer formatter.
// ----------------------------------------------------------------------------
package itfa_pkg;

    localparam logic [1:0] FMT_SDEC = 2'd0;
    localparam logic [1:0] FMT_UDEC = 2'd1;
    localparam logic [1:0] FMT_HEXL = 2'd2;
    localparam logic [1:0] FMT_HEXU = 2'd3;

    localparam int PC_W      = 3;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int VAL_W     = 32;
    localparam int BITCNT_W  = 6;
    localparam int NDIG_W    = 4;
    localparam int COUNT_W   = 4;
    localparam int CHAR_W    = 7;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_LX    = 7'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 7'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;

    typedef enum logic [2:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_LASTBIT,
        HOLD_NORM,
        HOLD_SLOT
    } hold_t;

    typedef enum logic [1:0] {
        BR_NEVER,
        BR_ALWAYS,
        BR_HEX,
        BR_MORE
    } br_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_PRE1,
        EM_PRE2,
        EM_DIGIT
    } emit_t;

    typedef struct packed {
        logic            load;
        logic            dabble;
        logic            norm;
        emit_t           emit;
        hold_t           hold_sel;
        br_t             br;
        logic [PC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic bits_done;
        logic norm_done;
        logic slot_free;
        logic is_hex;
        logic more;
    } stat_t;

    function automatic ctl_t rom_word(input logic [PC_W-1:0] pc);
        ctl_t w;
        w = '{load: 1'b0, dabble: 1'b0, norm: 1'b0, emit: EM_NONE,
              hold_sel: HOLD_NONE, br: BR_ALWAYS, target: '0};
        case (pc)
            3'd0:
            begin
                w.load     = 1'b1;
                w.hold_sel = HOLD_IN;
                w.br       = BR_HEX;
                w.target   = 3'd2;
            end
            3'd1:
            begin
                w.dabble   = 1'b1;
                w.hold_sel = HOLD_LASTBIT;
                w.br       = BR_NEVER;
            end
            3'd2:
            begin
                w.norm     = 1'b1;
                w.hold_sel = HOLD_NORM;
                w.br       = BR_NEVER;
            end
            3'd3:
            begin
                w.emit     = EM_PRE1;
                w.hold_sel = HOLD_SLOT;
                w.br       = BR_NEVER;
            end
            3'd4:
            begin
                w.emit     = EM_PRE2;
                w.hold_sel = HOLD_SLOT;
                w.br       = BR_NEVER;
            end
            3'd5:
            begin
                w.emit     = EM_DIGIT;
                w.hold_sel = HOLD_SLOT;
                w.br       = BR_MORE;
                w.target   = 3'd5;
            end
            default:
            begin
                w.br       = BR_ALWAYS;
                w.target   = 3'd0;
            end
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {3'b000, d};
        else
            c = (upper ? CH_UA : CH_LA) + {3'b000, d} - 7'd10;
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/itfa_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itfa_seq
// Step counter and control store: issues one control word per step, holds on
// a wait condition and takes conditional jumps.
// ----------------------------------------------------------------------------
module itfa_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire itfa_pkg::stat_t stat,
    output itfa_pkg::ctl_t      ctl,
    output logic                go
);
    import itfa_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign ctl = rom_word(pc_reg);

    always_comb
    begin
        case (ctl.hold_sel)
            HOLD_NONE:    go = 1'b1;
            HOLD_IN:      go = stat.in_valid;
            HOLD_LASTBIT: go = stat.bits_done;
            HOLD_NORM:    go = stat.norm_done;
            HOLD_SLOT:    go = stat.slot_free;
            default:      go = 1'b1;
        endcase
        case (ctl.br)
            BR_NEVER:  taken = 1'b0;
            BR_ALWAYS: taken = 1'b1;
            BR_HEX:    taken = stat.is_hex;
            BR_MORE:   taken = stat.more;
            default:   taken = 1'b0;
        endcase
        if (!go)
            pc_next = pc_reg;
        else if (taken)
            pc_next = ctl.target;
        else
            pc_next = pc_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule
`default_nettype wire

// ===== sv/integer_to_ascii_formatter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Converts a 32-bit value to ASCII text in printf d, u, x or X style.
// ----------------------------------------------------------------------------
// One item is handled at a time. A decimal item spends a load step, a
// shift-and-add-3 binary-to-BCD conversion of all 32 value bits and
// leading-zero removal. A hex item skips the conversion and goes from the
// load step to leading-zero removal. Then come two prefix steps and one
// cycle per digit while the output is not stalled, plus a step that returns
// to the load step. While a character waits on a stalled output, the
// sequence holds.
module integer_to_ascii_formatter_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                action,
    input  wire logic [31:0]               value,
    input  wire logic                      plus_flag,
    input  wire logic                      space_flag,
    input  wire logic                      hash_flag,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [itfa_pkg::CHAR_W-1:0]    char_code,
    output logic                           last_char,
    output logic [itfa_pkg::COUNT_W-1:0]   total_count
);
    import itfa_pkg::*;

    ctl_t  ctl;
    stat_t stat;
    logic  go;

    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [VAL_W-1:0]    mag_reg, mag_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [NDIG_W-1:0]   ndig_reg, ndig_next;
    logic [1:0]          plen_reg, plen_next;
    logic [CHAR_W-1:0]   pre1_reg, pre1_next;
    logic [CHAR_W-1:0]   pre2_reg, pre2_next;
    logic                upper_reg, upper_next;
    logic [COUNT_W-1:0]  total_reg, total_next;

    logic                ov_reg, ov_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    logic [BCD_W-1:0]    adj;
    logic                top_zero;
    logic                neg;
    logic                emit_en;

    itfa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl),
        .go    (go)
    );

    assign top_zero = (bcd_reg[BCD_W-1 -: 4] == 4'd0);
    assign neg      = (action == FMT_SDEC) && value[VAL_W-1];

    always_comb
    begin
        stat.in_valid  = in_valid;
        stat.bits_done = (bitcnt_reg == 6'd1);
        stat.norm_done = !top_zero || (ndig_reg == 4'd1);
        stat.slot_free = !ov_reg || !out_stall;
        stat.is_hex    = action[1];
        stat.more      = (ndig_reg != 4'd1);
    end

    assign in_stall = (ctl.hold_sel != HOLD_IN);

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bcd_next    = bcd_reg;
        mag_next    = mag_reg;
        bitcnt_next = bitcnt_reg;
        ndig_next   = ndig_reg;
        plen_next   = plen_reg;
        pre1_next   = pre1_reg;
        pre2_next   = pre2_reg;
        upper_next  = upper_reg;
        total_next  = total_reg;
        ov_next     = ov_reg && out_stall;
        char_next   = char_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;

        case (ctl.emit)
            EM_NONE:  emit_en = 1'b0;
            EM_PRE1:  emit_en = (plen_reg != 2'd0);
            EM_PRE2:  emit_en = (plen_reg == 2'd2);
            EM_DIGIT: emit_en = 1'b1;
            default:  emit_en = 1'b0;
        endcase

        if (ctl.load && go)
        begin
            bitcnt_next = 6'd32;
            upper_next  = (action == FMT_HEXU);
            pre1_next   = CH_ZERO;
            pre2_next   = (action == FMT_HEXU) ? CH_UX : CH_LX;
            plen_next   = 2'd0;
            if (action[1])
            begin
                bcd_next  = {value, 8'h00};
                mag_next  = '0;
                ndig_next = 4'd8;
                if (hash_flag && (value != '0))
                    plen_next = 2'd2;
            end
            else
            begin
                bcd_next  = '0;
                mag_next  = neg ? (32'd0 - value) : value;
                ndig_next = 4'd10;
                if (neg)
                begin
                    plen_next = 2'd1;
                    pre1_next = CH_MINUS;
                end
                else if ((action == FMT_SDEC) && plus_flag)
                begin
                    plen_next = 2'd1;
                    pre1_next = CH_PLUS;
                end
                else if ((action == FMT_SDEC) && space_flag)
                begin
                    plen_next = 2'd1;
                    pre1_next = CH_SPACE;
                end
            end
        end

        if (ctl.dabble)
        begin
            bcd_next    = {adj[BCD_W-2:0], mag_reg[VAL_W-1]};
            mag_next    = {mag_reg[VAL_W-2:0], 1'b0};
            bitcnt_next = bitcnt_reg - 6'd1;
        end

        if (ctl.norm)
        begin
            if (!stat.norm_done)
            begin
                bcd_next  = {bcd_reg[BCD_W-5:0], 4'h0};
                ndig_next = ndig_reg - 4'd1;
            end
            else
            begin
                total_next = {2'b00, plen_reg} + ndig_reg;
            end
        end

        if (go && emit_en)
        begin
            ov_next = 1'b1;
            case (ctl.emit)
                EM_PRE1:
                begin
                    char_next = pre1_reg;
                    last_next = 1'b0;
                    cnt_next  = '0;
                end
                EM_PRE2:
                begin
                    char_next = pre2_reg;
                    last_next = 1'b0;
                    cnt_next  = '0;
                end
                default:
                begin
                    char_next = digit_char(bcd_reg[BCD_W-1 -: 4], upper_reg);
                    last_next = (ndig_reg == 4'd1);
                    cnt_next  = (ndig_reg == 4'd1) ? total_reg : '0;
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'h0};
                    ndig_next = ndig_reg - 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        bcd_reg    <= bcd_next;
        mag_reg    <= mag_next;
        bitcnt_reg <= bitcnt_next;
        ndig_reg   <= ndig_next;
        plen_reg   <= plen_next;
        pre1_reg   <= pre1_next;
        pre2_reg   <= pre2_next;
        upper_reg  <= upper_next;
        total_reg  <= total_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        cnt_reg    <= cnt_next;
    end

    assign out_valid   = ov_reg;
    assign char_code   = char_reg;
    assign last_char   = last_reg;
    assign total_count = cnt_reg;

endmodule
`default_nettype wire

// ===== sv/itfa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itfa_checker
// Port-level checks for the integer formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itfa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [6:0]  char_code,
    input wire logic        last_char,
    input wire logic [3:0]  total_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(char_code)
            && $stable(last_char) && $stable(total_count)))
        else $error("Stalled output item changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("Input taken again right after an item.");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_char) |-> (total_count == 4'd0))
        else $error("Count shown on a character that is not the last.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_char) |-> (total_count >= 4'd1 && total_count <= 4'd11))
        else $error("Total count out of range.");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code >= 7'h20 && char_code <= 7'h7A))
        else $error("Character outside the printable set.");

endmodule

bind integer_to_ascii_formatter_unit itfa_checker u_itfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .last_char   (last_char),
    .total_count (total_count)
);
`default_nettype wire
